[hdl/int64_divider_assert.svh]
// Assertion macros shared by the divider modules.
`ifndef INT64_DIVIDER_ASSERT_SVH
`define INT64_DIVIDER_ASSERT_SVH
`ifndef SYNTH
`define I64_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("divider assertion failed");
`define I64_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("divider assertion failed");
`else
`define I64_ASSERT(lbl, clk, rst, prop)
`define I64_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/i64div_pkg.sv]
// Shared types and constants of the 64-bit divider.
`timescale 1ns / 1ps
package i64div_pkg;

  localparam int WORD_W      = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic neg;
    logic zero;
  } cls_t;

endpackage

[hdl/i64div_if.sv]
// Request and response channel interfaces of the divider.
`timescale 1ns / 1ps
interface i64div_req_if import i64div_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] dividend;
  logic [WORD_W-1:0] divisor;

  modport source (output valid, func, dividend, divisor, input ready);
  modport sink (input valid, func, dividend, divisor, output ready);
endinterface

interface i64div_rsp_if import i64div_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] quotient;
  logic [WORD_W-1:0] remainder;

  modport source (output valid, quotient, remainder, input ready);
  modport sink (input valid, quotient, remainder, output ready);
endinterface

[hdl/i64div_front.sv]
// Front stage: accepts requests, takes operand magnitudes and classifies them.
`timescale 1ns / 1ps
module i64div_front import i64div_pkg::*; #(
  parameter int DW = 64
) (
  input  logic             clk,
  input  logic             rst,
  i64div_req_if.sink       req,
  output logic             out_valid,
  input  logic             out_ready,
  output cls_t             out_cls,
  output logic [DW-1:0]    out_n,
  output logic [DW-1:0]    out_d
);

  logic          fv;
  cls_t          cls;
  logic [DW-1:0] n_mag;
  logic [DW-1:0] d_mag;
  logic [DW-1:0] n_in;
  logic [DW-1:0] d_in;
  logic          n_neg;
  logic          d_neg;
  logic          take;

  assign n_in  = req.dividend[DW-1:0];
  assign d_in  = req.divisor[DW-1:0];
  assign n_neg = req.func && n_in[DW-1];
  assign d_neg = req.func && d_in[DW-1];

  assign req.ready = !fv || out_ready;
  assign take      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (req.ready) begin
      fv <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      n_mag    <= n_neg ? (~n_in + DW'(1)) : n_in;
      d_mag    <= d_neg ? (~d_in + DW'(1)) : d_in;
      cls.neg  <= n_neg ^ d_neg;
      cls.zero <= (d_in == '0);
    end
  end

  assign out_valid = fv;
  assign out_cls   = cls;
  assign out_n     = n_mag;
  assign out_d     = d_mag;

endmodule

[hdl/i64div_queue.sv]
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
`include "int64_divider_assert.svh"
module i64div_queue import i64div_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign in_ready  = (count != CW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= in_data;
    end
  end

  `I64_ASSERT(q_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))
  `I64_ASSERT_NEXT(q_fill_step, clk, rst, wr && !rd, count == $past(count) + CW'(1))

endmodule

[hdl/i64div_back.sv]
// Back part: one restoring subtract stage per quotient bit, then sign fixup.
`timescale 1ns / 1ps
`include "int64_divider_assert.svh"
module i64div_back import i64div_pkg::*; #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cls_t          in_cls,
  input  logic [DW-1:0] in_n,
  input  logic [DW-1:0] in_d,
  i64div_rsp_if.source  rsp
);

  // Each stage holds the partial remainder and a word that shifts dividend bits
  // out at the top while quotient bits enter at the bottom.
  function automatic logic [2*DW-1:0] div_step(logic [DW-1:0] r, logic [DW-1:0] nq,
                                               logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] diff;
    t    = {r, nq[DW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[DW-1:0], nq[DW-2:0], 1'b1};
    end
    return {t[DW-1:0], nq[DW-2:0], 1'b0};
  endfunction

  logic [DW-1:0] v;
  logic [DW-1:0] rem [DW];
  logic [DW-1:0] nq  [DW];
  logic [DW-1:0] dq  [DW-1];
  cls_t          cls [DW];
  logic          out_v;
  logic [DW-1:0] out_q;
  logic [DW-1:0] out_r;
  logic          adv;

  assign adv      = !out_v || rsp.ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      out_v <= 1'b0;
    end else if (adv) begin
      v     <= {v[DW-2:0], in_valid};
      out_v <= v[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      {rem[0], nq[0]} <= div_step('0, in_n, in_d);
      dq[0]           <= in_d;
      cls[0]          <= in_cls;
    end
  end

  for (genvar g = 1; g < DW; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) begin
        {rem[g], nq[g]} <= div_step(rem[g-1], nq[g-1], dq[g-1]);
        cls[g]          <= cls[g-1];
      end
    end
    if (g < DW - 1) begin : g_div
      always_ff @(posedge clk) begin
        if (adv) begin
          dq[g] <= dq[g-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cls[DW-1].zero) begin
        out_q <= '0;
        out_r <= '0;
      end else begin
        out_q <= cls[DW-1].neg ? (~nq[DW-1] + DW'(1)) : nq[DW-1];
        out_r <= rem[DW-1];
      end
    end
  end

  assign rsp.valid     = out_v;
  assign rsp.quotient  = WORD_W'(out_q);
  assign rsp.remainder = WORD_W'(out_r);

  `I64_ASSERT_NEXT(b_last_to_out, clk, rst, adv && v[DW-1], out_v)

endmodule

[hdl/int64_divider.sv]
// Top level of the pipelined 64-bit restoring divider.
//
//   channel | dir | fields
//   req     | in  | func, dividend, divisor
//   rsp     | out | quotient, remainder
//
// One division enters per cycle while the response is not stalled; each item passes
// the front register, the queue, the DATA_WIDTH compare-and-subtract stages and the
// output register. Reset is synchronous and clears all valid state; no clearing
// pass is needed. A stalled response holds the back pipeline; the two-entry queue
// lets the front keep accepting until the queue is full while the back is stalled.
`timescale 1ns / 1ps
module int64_divider import i64div_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  i64div_req_if.sink   req,
  i64div_rsp_if.source rsp
);

  localparam int QW = $bits(cls_t) + 2 * DATA_WIDTH;

  logic                  f_valid;
  logic                  f_ready;
  cls_t                  f_cls;
  logic [DATA_WIDTH-1:0] f_n;
  logic [DATA_WIDTH-1:0] f_d;
  logic                  b_valid;
  logic                  b_ready;
  logic [QW-1:0]         b_data;
  cls_t                  b_cls;
  logic [DATA_WIDTH-1:0] b_n;
  logic [DATA_WIDTH-1:0] b_d;

  i64div_front #(.DW(DATA_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_cls   (f_cls),
    .out_n     (f_n),
    .out_d     (f_d)
  );

  i64div_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_cls, f_n, f_d}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign {b_cls, b_n, b_d} = b_data;

  i64div_back #(.DW(DATA_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_cls   (b_cls),
    .in_n     (b_n),
    .in_d     (b_d),
    .rsp      (rsp)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the pipelined 64-bit restoring divider.
`timescale 1ns / 1ps
module testbench;
  import i64div_pkg::*;

  typedef enum logic {
    DIV_UNSIGNED = 1'b0,
    DIV_SIGNED   = 1'b1
  } div_func_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
  } div_result_t;

  typedef struct {
    div_func_t func;
    word_t     dividend;
    word_t     divisor;
    bit        known;
    word_t     quotient;
    word_t     remainder;
  } div_case_t;

  localparam word_t ALL_ONES = {WORD_W{1'b1}};
  localparam word_t MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 500;
  localparam int DRAIN_CYCLES = 100;

  div_case_t directed_cases [N_DIRECTED] = '{
    '{DIV_UNSIGNED, 64'd0, 64'd0, 1'b1, 64'd0, 64'd0},
    '{DIV_UNSIGNED, ALL_ONES, 64'd0, 1'b1, 64'd0, 64'd0},
    '{DIV_SIGNED, MOST_NEG, 64'd0, 1'b1, 64'd0, 64'd0},
    '{DIV_UNSIGNED, ALL_ONES, 64'd1, 1'b1, ALL_ONES, 64'd0},
    '{DIV_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0},
    '{DIV_UNSIGNED, 64'd0, ALL_ONES, 1'b1, 64'd0, 64'd0},
    '{DIV_UNSIGNED, 64'd100, 64'd7, 1'b1, 64'd14, 64'd2},
    '{DIV_UNSIGNED, ALL_ONES, MOST_NEG, 1'b1, 64'd1, MOST_POS},
    '{DIV_UNSIGNED, MOST_NEG, 64'h8000_0000_0000_0001, 1'b1, 64'd0, MOST_NEG},
    '{DIV_UNSIGNED, ALL_ONES, 64'h8000_0000_0000_0001, 1'b1, 64'd1,
      64'h7FFF_FFFF_FFFF_FFFE},
    '{DIV_SIGNED, MOST_NEG, ALL_ONES, 1'b1, MOST_NEG, 64'd0},
    '{DIV_SIGNED, MOST_NEG, 64'd1, 1'b1, MOST_NEG, 64'd0},
    '{DIV_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b1, 64'hFFFF_FFFF_FFFF_FFFD, 64'd1},
    '{DIV_SIGNED, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFD, 64'd1},
    '{DIV_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 64'd3, 64'd1},
    '{DIV_SIGNED, MOST_POS, MOST_NEG, 1'b1, 64'd0, MOST_POS},
    '{DIV_SIGNED, MOST_NEG, MOST_NEG, 1'b1, 64'd1, 64'd0},
    '{DIV_SIGNED, ALL_ONES, ALL_ONES, 1'b1, 64'd1, 64'd0},
    '{DIV_SIGNED, MOST_POS, ALL_ONES, 1'b1, 64'h8000_0000_0000_0001, 64'd0},
    '{DIV_SIGNED, MOST_POS, 64'd2, 1'b1, 64'h3FFF_FFFF_FFFF_FFFF, 64'd1},
    '{DIV_UNSIGNED, 64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_F00D, 1'b0, 64'd0, 64'd0},
    '{DIV_SIGNED, 64'hDEAD_BEEF_0123_4567, 64'h0000_0000_0001_F00D, 1'b0, 64'd0, 64'd0},
    '{DIV_SIGNED, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_FFF0_0001, 1'b0, 64'd0, 64'd0},
    '{DIV_UNSIGNED, 64'h0123_4567_89AB_CDEF, 64'd3, 1'b0, 64'd0, 64'd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit calm = 1'b0;
  int mismatch_count = 0;
  div_result_t pending_results [$];

  i64div_req_if req_ch ();
  i64div_rsp_if rsp_ch ();

  int64_divider #(.DATA_WIDTH(WORD_W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic div_result_t divide_words(div_func_t func, word_t dividend,
                                               word_t divisor);
    div_result_t res;
    logic        neg_n;
    logic        neg_d;
    word_t       mag_n;
    word_t       mag_d;
    neg_n = (func == DIV_SIGNED) && dividend[WORD_W-1];
    neg_d = (func == DIV_SIGNED) && divisor[WORD_W-1];
    mag_n = neg_n ? word_t'(-dividend) : dividend;
    mag_d = neg_d ? word_t'(-divisor) : divisor;
    if (mag_d == '0) begin
      res = '0;
    end else begin
      res.quotient  = mag_n / mag_d;
      res.remainder = mag_n % mag_d;
      if (neg_n != neg_d) begin
        res.quotient = word_t'(-res.quotient);
      end
    end
    return res;
  endfunction

  function automatic word_t random_operand();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return w;
      1: return w >> $urandom_range(0, WORD_W - 1);
      2: return word_t'($urandom_range(0, 15));
      3: return word_t'(-$urandom_range(1, 16));
      4: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return word_t'(1);
          2: return ALL_ONES;
          3: return MOST_NEG;
          default: return MOST_POS;
        endcase
      end
      default: return (word_t'(1) << $urandom_range(0, WORD_W - 1))
                      + word_t'($urandom_range(0, 2)) - word_t'(1);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic issue_division(input div_func_t func, input word_t dividend,
                                input word_t divisor, input bit known,
                                input div_result_t typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= func;
    req_ch.dividend <= dividend;
    req_ch.divisor  <= divisor;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(known ? typed : divide_words(func, dividend, divisor));
    @(negedge clk);
  endtask

  initial begin
    int gap;
    div_result_t want;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected item q=%h r=%h", rsp_ch.quotient,
                             rsp_ch.remainder));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.quotient !== want.quotient) begin
          flag_error($sformatf("quotient expected %h got %h", want.quotient,
                               rsp_ch.quotient));
        end
        if (rsp_ch.remainder !== want.remainder) begin
          flag_error($sformatf("remainder expected %h got %h", want.remainder,
                               rsp_ch.remainder));
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    div_result_t typed;
    req_ch.valid    = 1'b0;
    req_ch.func     = DIV_UNSIGNED;
    req_ch.dividend = '0;
    req_ch.divisor  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_cases[i]) begin
      typed.quotient  = directed_cases[i].quotient;
      typed.remainder = directed_cases[i].remainder;
      issue_division(directed_cases[i].func, directed_cases[i].dividend,
                     directed_cases[i].divisor, directed_cases[i].known, typed);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 200) && (i < 300);
      issue_division(div_func_t'($urandom_range(0, 1)), random_operand(),
                     random_operand(), 1'b0, '0);
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[int64_divider] OK");
    end else begin
      $display("[int64_divider] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[int64_divider] ERROR");
    $finish;
  end

endmodule
